// ----- src/mcls_pkg.sv -----
// Package for the motor command link supervisor: types, codes and helper functions.
`default_nettype none

package mcls_pkg;

    typedef enum logic [1:0] {
        LINK_WAIT      = 2'd0,
        LINK_CONNECTED = 2'd1,
        LINK_LOST      = 2'd2
    } t_link_mode;

    typedef enum logic [1:0] {
        MOTOR_HEALTHY     = 2'd0,
        MOTOR_NOT_STARTED = 2'd1,
        MOTOR_FAILED      = 2'd2
    } t_motor_mode;

    // Input item kinds
    localparam logic [1:0] KIND_RX_BYTE  = 2'd0;
    localparam logic [1:0] KIND_OVERFLOW = 2'd1;
    localparam logic [1:0] KIND_START    = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OVF_PER_TICK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_LIM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DUTY    = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_OVF_PER_TICK = 16'd11100;
    localparam logic [7:0]  RST_MISS_LIMIT   = 8'd10;
    localparam logic [7:0]  RST_FAULT_LIMIT  = 8'd5;
    localparam logic [7:0]  RST_RECOVER_LIM  = 8'd3;
    localparam logic [7:0]  RST_BLINK_PERIOD = 8'd10;
    localparam logic [7:0]  RST_STOP_DUTY    = 8'd90;

    // Status codes sent back on a command
    localparam logic [7:0] STATUS_OK          = 8'hAA;
    localparam logic [7:0] STATUS_NOT_STARTED = 8'hBB;
    localparam logic [7:0] STATUS_FAILED      = 8'hCC;

    // Command bands
    localparam logic [7:0] BAND_A_LO = 8'd24;
    localparam logic [7:0] BAND_A_HI = 8'd68;
    localparam logic [7:0] BAND_B_LO = 8'd112;
    localparam logic [7:0] BAND_B_HI = 8'd235;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic command_valid(input logic [7:0] b, input logic [7:0] stop);
        return (b >= BAND_A_LO && b <= BAND_A_HI) ||
               (b >= BAND_B_LO && b <= BAND_B_HI) || (b == stop);
    endfunction

    function automatic logic [7:0] status_code(input t_motor_mode m);
        logic [7:0] code;
        case (m)
            MOTOR_HEALTHY: code = STATUS_OK;
            MOTOR_FAILED:  code = STATUS_FAILED;
            default:       code = STATUS_NOT_STARTED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- src/motor_command_link_supervisor_unit.sv -----
// Top level of the motor command link supervisor: input stage, update logic, result stage.
`default_nettype none
// Input register, then state and result registers; one item per cycle when not stalled.
// One pass of compare and saturating-count logic per item; a waiting result holds the
//   input register, and o_ready drops once both stages are full and i_ready is low.
// Reset (synchronous, active low): link waiting for sync, motor not started, counters zero,
//   duty at 90, LED on, configuration registers at their defaults, both stages empty.

module motor_command_link_supervisor_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [1:0]                        i_kind,
    input  wire logic [7:0]                        i_rx_byte,
    input  wire logic                              i_motor_signal,
    input  wire logic                              i_start_passed,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [7:0]                             o_duty,
    output logic                                   o_led,
    output logic                                   o_tx_valid,
    output logic [7:0]                             o_tx_byte,
    output logic [1:0]                             o_link_status,
    output logic [1:0]                             o_motor_status,
    output logic                                   o_tick_fired,
    // configuration channel
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [mcls_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [mcls_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // configuration
    logic [15:0] r_ovf_per_tick;
    logic [7:0]  r_miss_limit;
    logic [7:0]  r_fault_limit;
    logic [7:0]  r_recover_limit;
    logic [7:0]  r_blink_period;
    logic [7:0]  r_stop_duty;

    // input stage
    logic        r_in_vld;
    logic [1:0]  r_kind;
    logic [7:0]  r_rx_byte;
    logic        r_motor_signal;
    logic        r_start_passed;

    // supervisor state
    mcls_pkg::t_link_mode  r_link,  n_link;
    mcls_pkg::t_motor_mode r_motor, n_motor;
    logic        r_fresh,       n_fresh;
    logic [7:0]  r_miss_cnt,    n_miss_cnt;
    logic [7:0]  r_fault_cnt,   n_fault_cnt;
    logic [7:0]  r_recover_cnt, n_recover_cnt;
    logic [7:0]  r_blink_cnt,   n_blink_cnt;
    logic [15:0] r_ovf_cnt,     n_ovf_cnt;
    logic [7:0]  r_duty,        n_duty;
    logic        r_led,         n_led;
    logic        n_send;
    logic        n_tick;

    // result stage
    logic        r_out_vld;
    logic        r_out_tx_valid;
    logic [7:0]  r_out_tx_byte;
    logic        r_out_tick;

    logic        advance;

    assign advance     = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready     = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_per_tick  <= mcls_pkg::RST_OVF_PER_TICK;
            r_miss_limit    <= mcls_pkg::RST_MISS_LIMIT;
            r_fault_limit   <= mcls_pkg::RST_FAULT_LIMIT;
            r_recover_limit <= mcls_pkg::RST_RECOVER_LIM;
            r_blink_period  <= mcls_pkg::RST_BLINK_PERIOD;
            r_stop_duty     <= mcls_pkg::RST_STOP_DUTY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mcls_pkg::CFG_OVF_PER_TICK: r_ovf_per_tick  <= i_cfg_data;
                mcls_pkg::CFG_MISS_LIMIT:   r_miss_limit    <= i_cfg_data[7:0];
                mcls_pkg::CFG_FAULT_LIMIT:  r_fault_limit   <= i_cfg_data[7:0];
                mcls_pkg::CFG_RECOVER_LIM:  r_recover_limit <= i_cfg_data[7:0];
                mcls_pkg::CFG_BLINK_PERIOD: r_blink_period  <= i_cfg_data[7:0];
                mcls_pkg::CFG_STOP_DUTY:    r_stop_duty     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_kind         <= i_kind;
            r_rx_byte      <= i_rx_byte;
            r_motor_signal <= i_motor_signal;
            r_start_passed <= i_start_passed;
        end
    end

    // single-pass update; later steps see the values written by earlier ones
    always_comb begin
        n_link        = r_link;
        n_motor       = r_motor;
        n_fresh       = r_fresh;
        n_miss_cnt    = r_miss_cnt;
        n_fault_cnt   = r_fault_cnt;
        n_recover_cnt = r_recover_cnt;
        n_blink_cnt   = r_blink_cnt;
        n_ovf_cnt     = r_ovf_cnt;
        n_duty        = r_duty;
        n_led         = r_led;
        n_send        = 1'b0;
        n_tick        = 1'b0;

        case (r_kind)
            mcls_pkg::KIND_RX_BYTE: begin
                if (r_link == mcls_pkg::LINK_WAIT) begin
                    if (r_rx_byte == r_stop_duty) begin
                        n_link = mcls_pkg::LINK_CONNECTED;
                        n_send = 1'b1;
                    end
                end else if (mcls_pkg::command_valid(r_rx_byte, r_stop_duty)) begin
                    n_duty  = r_rx_byte;
                    n_led   = !r_led;
                    n_fresh = 1'b1;
                    n_link  = mcls_pkg::LINK_CONNECTED;
                    n_send  = 1'b1;
                end
            end
            mcls_pkg::KIND_OVERFLOW: begin
                n_ovf_cnt = r_ovf_cnt + 16'd1;
                if (n_ovf_cnt >= r_ovf_per_tick) begin
                    n_ovf_cnt = '0;
                    n_tick    = 1'b1;
                    // link supervision
                    if (r_link == mcls_pkg::LINK_CONNECTED) begin
                        if (r_fresh) begin
                            n_miss_cnt = '0;
                            n_fresh    = 1'b0;
                        end else begin
                            n_led      = 1'b0;
                            n_miss_cnt = mcls_pkg::sat_inc(r_miss_cnt);
                            if (n_miss_cnt >= r_miss_limit) begin
                                n_duty = r_stop_duty;
                                n_link = mcls_pkg::LINK_LOST;
                            end
                        end
                    end else if (r_link == mcls_pkg::LINK_LOST) begin
                        n_blink_cnt = mcls_pkg::sat_inc(r_blink_cnt);
                        if (n_blink_cnt >= r_blink_period) begin
                            n_led       = !r_led;
                            n_blink_cnt = '0;
                        end
                    end
                    // motor line debounce
                    if (!r_motor_signal && r_motor == mcls_pkg::MOTOR_HEALTHY) begin
                        n_recover_cnt = '0;
                        n_fault_cnt   = mcls_pkg::sat_inc(r_fault_cnt);
                        if (n_fault_cnt >= r_fault_limit) begin
                            n_duty  = r_stop_duty;
                            n_motor = mcls_pkg::MOTOR_FAILED;
                        end
                    end else if (r_motor_signal && r_motor == mcls_pkg::MOTOR_FAILED) begin
                        n_fault_cnt   = '0;
                        n_recover_cnt = mcls_pkg::sat_inc(r_recover_cnt);
                        if (n_recover_cnt >= r_recover_limit) begin
                            n_motor = mcls_pkg::MOTOR_HEALTHY;
                        end
                    end
                end
            end
            mcls_pkg::KIND_START: begin
                if (r_start_passed) begin
                    n_motor = mcls_pkg::MOTOR_HEALTHY;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link        <= mcls_pkg::LINK_WAIT;
            r_motor       <= mcls_pkg::MOTOR_NOT_STARTED;
            r_fresh       <= 1'b0;
            r_miss_cnt    <= '0;
            r_fault_cnt   <= '0;
            r_recover_cnt <= '0;
            r_blink_cnt   <= '0;
            r_ovf_cnt     <= '0;
            r_duty        <= mcls_pkg::RST_STOP_DUTY;
            r_led         <= 1'b1;
        end else if (advance) begin
            r_link        <= n_link;
            r_motor       <= n_motor;
            r_fresh       <= n_fresh;
            r_miss_cnt    <= n_miss_cnt;
            r_fault_cnt   <= n_fault_cnt;
            r_recover_cnt <= n_recover_cnt;
            r_blink_cnt   <= n_blink_cnt;
            r_ovf_cnt     <= n_ovf_cnt;
            r_duty        <= n_duty;
            r_led         <= n_led;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tx_valid <= n_send;
            r_out_tx_byte  <= n_send ? mcls_pkg::status_code(n_motor) : 8'h00;
            r_out_tick     <= n_tick;
        end
    end

    // state registers are only touched on advance, so they hold the result's view
    assign o_valid        = r_out_vld;
    assign o_duty         = r_duty;
    assign o_led          = r_led;
    assign o_tx_valid     = r_out_tx_valid;
    assign o_tx_byte      = r_out_tx_byte;
    assign o_link_status  = r_link;
    assign o_motor_status = r_motor;
    assign o_tick_fired   = r_out_tick;

    // assertions
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tx_valid) |-> (o_tx_byte == 8'h00))
        else $error("status byte set without transmit");

    a_tick_no_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tick_fired) |-> !o_tx_valid)
        else $error("tick and transmit in one result");

    a_fail_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_motor == mcls_pkg::MOTOR_FAILED && r_motor == mcls_pkg::MOTOR_HEALTHY)
        |=> (r_duty == r_stop_duty))
        else $error("motor fault did not force stop duty");

    a_lost_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_link == mcls_pkg::LINK_LOST && r_link == mcls_pkg::LINK_CONNECTED)
        |=> (r_duty == r_stop_duty))
        else $error("link loss did not force stop duty");

    a_no_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_link != mcls_pkg::LINK_WAIT) |=> (r_link != mcls_pkg::LINK_WAIT))
        else $error("link returned to waiting for sync");

endmodule

`default_nettype wire

// ----- test/motor_command_link_supervisor_unit_test.sv -----
// Self-checking testbench for the motor command link supervisor: directed table, then random phases.
module motor_command_link_supervisor_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 10;
    localparam int NUM_PHASES     = 10;
    localparam int HOLD_PHASE     = 2;
    localparam int MAX_PHASE      = 3;
    localparam int DRAIN_PHASE    = 5;
    localparam int SAT_PHASE      = 6;
    localparam int ZERO_PHASE     = 8;
    localparam int SCRIPT_LEN     = 32;

    localparam logic [1:0] K_RX     = mcls_pkg::KIND_RX_BYTE;
    localparam logic [1:0] K_OVF    = mcls_pkg::KIND_OVERFLOW;
    localparam logic [1:0] K_START  = mcls_pkg::KIND_START;
    localparam logic [1:0] K_UNUSED = 2'd3;
    localparam logic [mcls_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic [7:0] duty;
        logic       led;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] link;
        logic [1:0] motor;
        logic       tick;
    } t_supervisor_result;

    typedef struct packed {
        logic [15:0] ticks;
        logic [7:0]  miss;
        logic [7:0]  fault;
        logic [7:0]  recover;
        logic [7:0]  blink;
        logic [7:0]  stop;
    } t_supervisor_setup;

    typedef enum logic { ROW_ITEM, ROW_SETUP } t_row_op;

    typedef struct packed {
        t_row_op            op;
        logic [1:0]         setup;
        logic [1:0]         kind;
        logic [7:0]         rx;
        logic               sig;
        logic               passed;
        logic               typed;
        t_supervisor_result want;
    } t_script_row;

    localparam t_supervisor_result NO_WANT = '0;
    localparam t_supervisor_result AT_RESET =
        '{8'd90, 1'b1, 1'b0, 8'h00, mcls_pkg::LINK_WAIT, mcls_pkg::MOTOR_NOT_STARTED, 1'b0};
    localparam t_supervisor_result SYNCED =
        '{8'd90, 1'b1, 1'b1, mcls_pkg::STATUS_NOT_STARTED, mcls_pkg::LINK_CONNECTED,
          mcls_pkg::MOTOR_NOT_STARTED, 1'b0};
    localparam t_supervisor_result SYNCED_QUIET =
        '{8'd90, 1'b1, 1'b0, 8'h00, mcls_pkg::LINK_CONNECTED,
          mcls_pkg::MOTOR_NOT_STARTED, 1'b0};
    localparam t_supervisor_result BAND_A_BOTTOM =
        '{8'd24, 1'b0, 1'b1, mcls_pkg::STATUS_NOT_STARTED, mcls_pkg::LINK_CONNECTED,
          mcls_pkg::MOTOR_NOT_STARTED, 1'b0};
    localparam t_supervisor_result BAND_A_TOP =
        '{8'd68, 1'b1, 1'b1, mcls_pkg::STATUS_NOT_STARTED, mcls_pkg::LINK_CONNECTED,
          mcls_pkg::MOTOR_NOT_STARTED, 1'b0};

    // 0: fastest ticks, stop at 0; 1: all limits zero, stop at 255;
    // 2: maxima; 3: tick count lowered below the running overflow count
    t_supervisor_setup directed_setups [4] = '{
        '{16'd1,    8'd1,   8'd1,   8'd1,   8'd1,   8'd0},
        '{16'd0,    8'd0,   8'd0,   8'd0,   8'd0,   8'd255},
        '{16'hFFFF, 8'hFF,  8'hFF,  8'hFF,  8'hFF,  8'd90},
        '{16'd2,    8'd3,   8'd2,   8'd2,   8'd2,   8'd128}
    };

    t_script_row directed_script [SCRIPT_LEN] = '{
        '{ROW_ITEM,  2'd0, K_UNUSED, 8'hFF,  1'b1, 1'b1, 1'b1, AT_RESET},
        '{ROW_ITEM,  2'd0, K_START,  8'h00,  1'b0, 1'b0, 1'b1, AT_RESET},
        '{ROW_ITEM,  2'd0, K_RX,     8'd24,  1'b0, 1'b0, 1'b1, AT_RESET},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b0, 1'b0, 1'b1, AT_RESET},
        '{ROW_ITEM,  2'd0, K_RX,     8'd90,  1'b0, 1'b0, 1'b1, SYNCED},
        '{ROW_ITEM,  2'd0, K_RX,     8'd0,   1'b0, 1'b0, 1'b1, SYNCED_QUIET},
        '{ROW_ITEM,  2'd0, K_RX,     8'd255, 1'b0, 1'b0, 1'b1, SYNCED_QUIET},
        '{ROW_ITEM,  2'd0, K_RX,     8'd24,  1'b0, 1'b0, 1'b1, BAND_A_BOTTOM},
        '{ROW_ITEM,  2'd0, K_RX,     8'd68,  1'b0, 1'b0, 1'b1, BAND_A_TOP},
        '{ROW_ITEM,  2'd0, K_RX,     8'd69,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_RX,     8'd112, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_RX,     8'd235, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_RX,     8'd236, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_START,  8'h00,  1'b0, 1'b1, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_RX,     8'd90,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_SETUP, 2'd0, K_RX,     8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_RX,     8'd200, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_RX,     8'd0,   1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_SETUP, 2'd2, K_RX,     8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_SETUP, 2'd3, K_RX,     8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{ROW_SETUP, 2'd1, K_RX,     8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_RX,     8'd255, 1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b0, 1'b0, 1'b0, NO_WANT},
        '{ROW_ITEM,  2'd0, K_OVF,    8'h00,  1'b1, 1'b0, 1'b0, NO_WANT}
    };

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_valid        = 1'b0;
    logic [1:0]                      i_kind         = '0;
    logic [7:0]                      i_rx_byte      = '0;
    logic                            i_motor_signal = 1'b0;
    logic                            i_start_passed = 1'b0;
    logic                            i_ready        = 1'b0;
    logic                            i_cfg_valid    = 1'b0;
    logic [mcls_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [mcls_pkg::CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                            o_ready;
    logic                            o_valid;
    logic [7:0]                      o_duty;
    logic                            o_led;
    logic                            o_tx_valid;
    logic [7:0]                      o_tx_byte;
    logic [1:0]                      o_link_status;
    logic [1:0]                      o_motor_status;
    logic                            o_tick_fired;
    logic                            o_cfg_ready;

    // predicted supervisor state and its register copy
    mcls_pkg::t_link_mode  link_state     = mcls_pkg::LINK_WAIT;
    mcls_pkg::t_motor_mode pred_motor     = mcls_pkg::MOTOR_NOT_STARTED;
    logic                  command_seen   = 1'b0;
    logic [7:0]            miss_count     = '0;
    logic [7:0]            fault_count    = '0;
    logic [7:0]            recover_count  = '0;
    logic [7:0]            blink_count    = '0;
    logic [15:0]           overflow_count = '0;
    logic [7:0]            duty_level     = 8'd90;
    logic                  led_level      = 1'b1;

    logic [15:0] cfg_ticks   = mcls_pkg::RST_OVF_PER_TICK;
    logic [7:0]  cfg_miss    = mcls_pkg::RST_MISS_LIMIT;
    logic [7:0]  cfg_fault   = mcls_pkg::RST_FAULT_LIMIT;
    logic [7:0]  cfg_recover = mcls_pkg::RST_RECOVER_LIM;
    logic [7:0]  cfg_blink   = mcls_pkg::RST_BLINK_PERIOD;
    logic [7:0]  cfg_stop    = mcls_pkg::RST_STOP_DUTY;

    t_supervisor_result expected_results [$];
    int                 mismatch_count = 0;
    int                 results_taken  = 0;
    int                 idle_cycles    = 0;
    logic               gaps_on        = 1'b1;
    logic               hold_req       = 1'b0;

    motor_command_link_supervisor_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_rx_byte      (i_rx_byte),
        .i_motor_signal (i_motor_signal),
        .i_start_passed (i_start_passed),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_duty         (o_duty),
        .o_led          (o_led),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_link_status  (o_link_status),
        .o_motor_status (o_motor_status),
        .o_tick_fired   (o_tick_fired),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [7:0] count_up(input logic [7:0] v);
        return v + {7'd0, v != 8'hFF};
    endfunction

    // Advances the predicted state by one transaction and returns what the block should report.
    function automatic t_supervisor_result supervise(input logic [1:0] kind, input logic [7:0] rx,
                                                     input logic sig, input logic passed);
        t_supervisor_result r;
        logic               sent;
        logic               ticked;
        logic               is_command;
        logic [7:0]         status;
        sent       = 1'b0;
        ticked     = 1'b0;
        is_command = (rx >= mcls_pkg::BAND_A_LO && rx <= mcls_pkg::BAND_A_HI) ||
                     (rx >= mcls_pkg::BAND_B_LO && rx <= mcls_pkg::BAND_B_HI) || rx == cfg_stop;
        case (kind)
            mcls_pkg::KIND_RX_BYTE: begin
                if (link_state == mcls_pkg::LINK_WAIT) begin
                    if (rx == cfg_stop) begin
                        link_state = mcls_pkg::LINK_CONNECTED;
                        sent       = 1'b1;
                    end
                end else if (is_command) begin
                    duty_level   = rx;
                    led_level    = ~led_level;
                    command_seen = 1'b1;
                    link_state   = mcls_pkg::LINK_CONNECTED;
                    sent         = 1'b1;
                end
            end
            mcls_pkg::KIND_OVERFLOW: begin
                overflow_count = overflow_count + 16'd1;
                if (overflow_count >= cfg_ticks) begin
                    overflow_count = '0;
                    ticked         = 1'b1;
                    if (link_state == mcls_pkg::LINK_CONNECTED) begin
                        if (command_seen) begin
                            miss_count   = '0;
                            command_seen = 1'b0;
                        end else begin
                            led_level  = 1'b0;
                            miss_count = count_up(miss_count);
                            if (miss_count >= cfg_miss) begin
                                duty_level = cfg_stop;
                                link_state = mcls_pkg::LINK_LOST;
                            end
                        end
                    end else if (link_state == mcls_pkg::LINK_LOST) begin
                        blink_count = count_up(blink_count);
                        if (blink_count >= cfg_blink) begin
                            led_level   = ~led_level;
                            blink_count = '0;
                        end
                    end
                    // motor line debounce; a not-started motor is left alone
                    if (!sig && pred_motor == mcls_pkg::MOTOR_HEALTHY) begin
                        recover_count = '0;
                        fault_count   = count_up(fault_count);
                        if (fault_count >= cfg_fault) begin
                            duty_level = cfg_stop;
                            pred_motor = mcls_pkg::MOTOR_FAILED;
                        end
                    end else if (sig && pred_motor == mcls_pkg::MOTOR_FAILED) begin
                        fault_count   = '0;
                        recover_count = count_up(recover_count);
                        if (recover_count >= cfg_recover) pred_motor = mcls_pkg::MOTOR_HEALTHY;
                    end
                end
            end
            mcls_pkg::KIND_START: begin
                if (passed) pred_motor = mcls_pkg::MOTOR_HEALTHY;
            end
            default: ;
        endcase
        case (pred_motor)
            mcls_pkg::MOTOR_HEALTHY: status = mcls_pkg::STATUS_OK;
            mcls_pkg::MOTOR_FAILED:  status = mcls_pkg::STATUS_FAILED;
            default:                 status = mcls_pkg::STATUS_NOT_STARTED;
        endcase
        r.duty     = duty_level;
        r.led      = led_level;
        r.tx_valid = sent;
        r.tx_byte  = sent ? status : 8'h00;
        r.link     = link_state;
        r.motor    = pred_motor;
        r.tick     = ticked;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_taken, name, got, want));
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [7:0] rx, input logic sig,
                             input logic passed, input logic typed,
                             input t_supervisor_result want);
        int                 gap;
        t_supervisor_result predicted;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_rx_byte      <= rx;
        i_motor_signal <= sig;
        i_start_passed <= passed;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predicted = supervise(kind, rx, sig, passed);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // valid stays high across a batch of writes; the caller lowers it
    task automatic write_register(input logic [mcls_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            mcls_pkg::CFG_OVF_PER_TICK: cfg_ticks   = data;
            mcls_pkg::CFG_MISS_LIMIT:   cfg_miss    = data[7:0];
            mcls_pkg::CFG_FAULT_LIMIT:  cfg_fault   = data[7:0];
            mcls_pkg::CFG_RECOVER_LIM:  cfg_recover = data[7:0];
            mcls_pkg::CFG_BLINK_PERIOD: cfg_blink   = data[7:0];
            mcls_pkg::CFG_STOP_DUTY:    cfg_stop    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic program_registers(input t_supervisor_setup s);
        write_register(mcls_pkg::CFG_OVF_PER_TICK, s.ticks);
        write_register(mcls_pkg::CFG_MISS_LIMIT, {8'($urandom), s.miss});
        write_register(mcls_pkg::CFG_FAULT_LIMIT, {8'($urandom), s.fault});
        write_register(mcls_pkg::CFG_RECOVER_LIM, {8'($urandom), s.recover});
        write_register(mcls_pkg::CFG_BLINK_PERIOD, {8'($urandom), s.blink});
        write_register(mcls_pkg::CFG_STOP_DUTY, {8'($urandom), s.stop});
        write_register(CFG_IDX_SPARE, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int                 stall;
        t_supervisor_result want;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_req) begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                stall = gaps_on ? $urandom_range(0, 9) : 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            results_taken++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_taken));
            end else begin
                want = expected_results.pop_front();
                check_field("duty", o_duty, want.duty);
                check_field("led", o_led, want.led);
                check_field("tx_valid", o_tx_valid, want.tx_valid);
                check_field("tx_byte", o_tx_byte, want.tx_byte);
                check_field("link_status", o_link_status, want.link);
                check_field("motor_status", o_motor_status, want.motor);
                check_field("tick_fired", o_tick_fired, want.tick);
            end
        end
    end

    initial begin
        int                phase;
        int                n;
        int                items;
        int                cmd_pct;
        int                low_pct;
        int                pick;
        t_supervisor_setup setup;
        logic [1:0]        kind;
        logic [7:0]        rx;
        logic              sig;
        logic              passed;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_script[r]) begin
            if (directed_script[r].op == ROW_SETUP) begin
                wait_for_results();
                program_registers(directed_setups[directed_script[r].setup]);
            end else begin
                send_item(directed_script[r].kind, directed_script[r].rx, directed_script[r].sig,
                          directed_script[r].passed, directed_script[r].typed,
                          directed_script[r].want);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            setup.ticks   = 16'($urandom_range(0, 5));
            setup.miss    = 8'($urandom_range(1, 6));
            setup.fault   = 8'($urandom_range(1, 6));
            setup.recover = 8'($urandom_range(1, 5));
            setup.blink   = 8'($urandom_range(1, 4));
            setup.stop    = $urandom_range(0, 1) ? mcls_pkg::RST_STOP_DUTY : 8'($urandom);
            cmd_pct       = $urandom_range(5, 60);
            low_pct       = $urandom_range(0, 100);
            items         = 90;
            if (phase == MAX_PHASE) begin
                setup = '{16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, setup.stop};
            end else if (phase == ZERO_PHASE) begin
                setup = '{16'd0, 8'd0, 8'd0, 8'd0, 8'd0, setup.stop};
            end else if (phase == SAT_PHASE) begin
                // a long run of low-signal ticks drives the fault count into saturation
                setup.ticks = '0;
                setup.fault = 8'hFF;
                cmd_pct     = 3;
                low_pct     = 100;
                items       = 340;
            end
            wait_for_results();
            program_registers(setup);
            gaps_on = (phase % 3 != 1);

            for (n = 0; n < items; n++) begin
                if (phase == HOLD_PHASE && n == 40) hold_req = 1'b1;
                if (phase == DRAIN_PHASE && n == 45) wait_for_results();
                pick   = $urandom_range(0, 99);
                rx     = 8'($urandom);
                sig    = 1'($urandom);
                passed = 1'($urandom);
                if (pick < cmd_pct) begin
                    kind = K_RX;
                    case ($urandom_range(0, 3))
                        0: rx = 8'($urandom_range(mcls_pkg::BAND_A_LO, mcls_pkg::BAND_A_HI));
                        1: rx = 8'($urandom_range(mcls_pkg::BAND_B_LO, mcls_pkg::BAND_B_HI));
                        2: rx = cfg_stop;
                        default: ;
                    endcase
                end else if (pick < 92) begin
                    kind = K_OVF;
                    sig  = ($urandom_range(0, 99) >= low_pct);
                end else if (pick < 97) begin
                    kind = K_START;
                end else begin
                    kind = K_UNUSED;
                end
                send_item(kind, rx, sig, passed, 1'b0, NO_WANT);
            end
        end

        gaps_on = 1'b1;
        wait_for_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
